// ===== hdl/ssd_pkg.sv =====
// Shared types, opcodes, segment tables and animation pattern function.
package ssd_pkg;

    localparam int unsigned DELAY_W = 24;
    localparam logic [DELAY_W-1:0] DLY_MASK = '1;
    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(100000);
    localparam logic [3:0] STEP_WRAP = 4'd12;

    // input function codes
    localparam logic [3:0] F_DIGIT  = 4'd0;
    localparam logic [3:0] F_HEX    = 4'd1;
    localparam logic [3:0] F_CHAR   = 4'd2;
    localparam logic [3:0] F_RAW    = 4'd3;
    localparam logic [3:0] F_SETSEG = 4'd4;
    localparam logic [3:0] F_TOGSEG = 4'd5;
    localparam logic [3:0] F_BLANK  = 4'd6;
    localparam logic [3:0] F_ALL    = 4'd7;
    localparam logic [3:0] F_MINUS  = 4'd8;
    localparam logic [3:0] F_UNDER  = 4'd9;
    localparam logic [3:0] F_DEGREE = 4'd10;
    localparam logic [3:0] F_ERROR  = 4'd11;
    localparam logic [3:0] F_START  = 4'd12;
    localparam logic [3:0] F_STOP   = 4'd13;
    localparam logic [3:0] F_TICK   = 4'd14;

    // classified operations handed to the back end
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_DRAW   = 3'd1;
    localparam logic [2:0] OP_SETSEG = 3'd2;
    localparam logic [2:0] OP_TOGSEG = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;

    // animation modes
    localparam logic [2:0] MODE_CW    = 3'd0;
    localparam logic [2:0] MODE_CCW   = 3'd1;
    localparam logic [2:0] MODE_BLINK = 3'd2;
    localparam logic [2:0] MODE_CHASE = 3'd3;
    localparam logic [2:0] MODE_LOAD  = 3'd4;

    // port bit order msb..lsb: A F B G E C D DP
    localparam logic [2:0] BIT_A = 3'd7;
    localparam logic [2:0] BIT_F = 3'd6;
    localparam logic [2:0] BIT_B = 3'd5;
    localparam logic [2:0] BIT_E = 3'd3;
    localparam logic [2:0] BIT_C = 3'd2;
    localparam logic [2:0] BIT_D = 3'd1;
    localparam logic [2:0] BIT_DP = 3'd0;

    localparam logic [7:0] SYM_BLANK  = 8'h00;
    localparam logic [7:0] SYM_ALL    = 8'hFF;
    localparam logic [7:0] SYM_MINUS  = 8'h10;
    localparam logic [7:0] SYM_UNDER  = 8'h02;
    localparam logic [7:0] SYM_DEGREE = 8'hF0;
    localparam logic [7:0] SYM_ERROR  = 8'hDA;
    localparam logic [7:0] SYM_LETTER_R = 8'h18;

    localparam logic [7:0] NUM_TAB [10] = '{
        8'hEE, 8'h24, 8'hBA, 8'hB6, 8'h74, 8'hD6, 8'hDE, 8'hA4, 8'hFE, 8'hF6
    };
    localparam logic [7:0] HEXL_TAB [6] = '{
        8'hFC, 8'h5E, 8'hCA, 8'h3E, 8'hDA, 8'hD8
    };
    localparam logic [2:0] RING [6] = '{BIT_A, BIT_B, BIT_C, BIT_D, BIT_E, BIT_F};

    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         pat;     // pattern before polarity inversion
        logic               dp;
        logic [2:0]         seg;
        logic               seg_on;
        logic               acc;
        logic [2:0]         kind;
        logic [DELAY_W-1:0] delay;
    } t_cmd;

    // {valid, pattern} for one animation step; step stays below STEP_WRAP
    function automatic logic [8:0] anim_pattern(input logic [2:0] mode,
                                                input logic [3:0] step);
        logic [2:0] s6;
        logic [2:0] s7;
        logic [2:0] idx;
        logic [3:0] sum;
        logic [7:0] pat;
        logic       ok;
        s6  = (step >= 4'd6) ? 3'(step - 4'd6) : step[2:0];
        s7  = (step >= 4'd7) ? 3'(step - 4'd7) : step[2:0];
        pat = 8'h00;
        ok  = 1'b1;
        idx = 3'd0;
        sum = 4'd0;
        case (mode)
            MODE_CW: begin
                pat = 8'b1 << RING[s6];
            end
            MODE_CCW: begin
                idx = (s6 == 3'd0) ? 3'd0 : 3'(3'd6 - s6);
                pat = 8'b1 << RING[idx];
            end
            MODE_BLINK: begin
                pat = step[0] ? SYM_BLANK : NUM_TAB[0];
            end
            MODE_CHASE: begin
                for (int i = 0; i < 3; i++) begin
                    sum = {1'b0, s6} + 4'(i);
                    idx = (sum >= 4'd6) ? 3'(sum - 4'd6) : sum[2:0];
                    pat = pat | (8'b1 << RING[idx]);
                end
            end
            MODE_LOAD: begin
                for (int i = 0; i < 6; i++) begin
                    if (3'(i) <= s7) begin
                        pat = pat | (8'b1 << RING[i]);
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        return {ok, pat};
    endfunction

endpackage

// ===== hdl/seven_segment_display_controller_unit.sv =====
// Seven-segment digit controller: command stream in, port status stream out.
// An accepted request is written to the queue, then applied into the back end's output register.
// Throughput: one request per cycle while the output is not stalled.
// A two-entry queue absorbs two requests while the output stalls.
// Synchronous active-low reset: port byte 0, animation stopped, delay 100000,
// port inversion on.
module seven_segment_display_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // 1: invert port byte, low bit lights
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // code[7:0], show_dp[8], segment[16:9], seg_on[17], anim_kind[20:18],
    // delay_ticks[44:21], zero fill[47:45]
    input  logic [47:0] s_axis_tdata,
    input  logic [3:0]  s_axis_tuser,    // func[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // port_bits[7:0], dp_lit[8], animating[9], accepted[10], wrote[11], zero fill[15:12]
    output logic [15:0] m_axis_tdata
);

    ssd_pkg::t_cmd front_cmd;
    ssd_pkg::t_cmd queue_cmd;
    logic          queue_ready;
    logic          queue_valid;
    logic          queue_pop;
    logic [7:0]    port_bits;
    logic          dp_lit;
    logic          animating;
    logic          accepted;
    logic          wrote;

    ssd_front u_front (
        .i_func        (s_axis_tuser),
        .i_code        (s_axis_tdata[7:0]),
        .i_show_dp     (s_axis_tdata[8]),
        .i_segment     (s_axis_tdata[16:9]),
        .i_seg_on      (s_axis_tdata[17]),
        .i_anim_kind   (s_axis_tdata[20:18]),
        .i_delay_ticks (s_axis_tdata[44:21]),
        .o_cmd         (front_cmd)
    );

    ssd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (front_cmd),
        .o_ready (queue_ready),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    ssd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_port_bits (port_bits),
        .o_dp_lit    (dp_lit),
        .o_animating (animating),
        .o_accepted  (accepted),
        .o_wrote     (wrote)
    );

    assign s_axis_tready = queue_ready;
    assign m_axis_tdata  = {4'b0, wrote, accepted, animating, dp_lit, port_bits};

endmodule

// ===== hdl/ssd_front.sv =====
// Front end: decodes each command request into a classified operation.
module ssd_front (
    input  logic [3:0]                 i_func,
    input  logic [7:0]                 i_code,
    input  logic                       i_show_dp,
    input  logic [7:0]                 i_segment,
    input  logic                       i_seg_on,
    input  logic [2:0]                 i_anim_kind,
    input  logic [ssd_pkg::DELAY_W-1:0] i_delay_ticks,
    output ssd_pkg::t_cmd              o_cmd
);

    logic [7:0] char_fold;
    logic [7:0] disp_pat;
    logic [7:0] sym_pat;

    // case-folded character
    assign char_fold = (i_code >= 8'h61 && i_code <= 8'h7A) ? 8'(i_code - 8'h20) : i_code;

    always_comb begin
        disp_pat = ssd_pkg::SYM_BLANK;
        case (i_func)
            ssd_pkg::F_DIGIT: begin
                if (i_code <= 8'd9) disp_pat = ssd_pkg::NUM_TAB[i_code[3:0]];
            end
            ssd_pkg::F_HEX: begin
                if (i_code <= 8'd9) disp_pat = ssd_pkg::NUM_TAB[i_code[3:0]];
                else if (i_code <= 8'd15) disp_pat = ssd_pkg::HEXL_TAB[3'(i_code - 8'd10)];
            end
            ssd_pkg::F_CHAR: begin
                if (char_fold >= 8'h30 && char_fold <= 8'h39) begin
                    disp_pat = ssd_pkg::NUM_TAB[char_fold[3:0]];
                end else if (char_fold >= 8'h41 && char_fold <= 8'h46) begin
                    disp_pat = ssd_pkg::HEXL_TAB[3'(char_fold - 8'h41)];
                end else if (char_fold == 8'h52) begin
                    disp_pat = ssd_pkg::SYM_LETTER_R;
                end else if (char_fold >= 8'h47 && char_fold <= 8'h5A) begin
                    disp_pat = ssd_pkg::SYM_MINUS;
                end else if (char_fold == 8'h2D) begin
                    disp_pat = ssd_pkg::SYM_MINUS;
                end else if (char_fold == 8'h5F) begin
                    disp_pat = ssd_pkg::SYM_UNDER;
                end
            end
            default: begin
                disp_pat = i_code;
            end
        endcase
    end

    always_comb begin
        case (i_func)
            ssd_pkg::F_ALL:    sym_pat = ssd_pkg::SYM_ALL;
            ssd_pkg::F_MINUS:  sym_pat = ssd_pkg::SYM_MINUS;
            ssd_pkg::F_UNDER:  sym_pat = ssd_pkg::SYM_UNDER;
            ssd_pkg::F_DEGREE: sym_pat = ssd_pkg::SYM_DEGREE;
            ssd_pkg::F_ERROR:  sym_pat = ssd_pkg::SYM_ERROR;
            default:           sym_pat = ssd_pkg::SYM_BLANK;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.acc    = 1'b1;
        o_cmd.seg    = i_segment[2:0];
        o_cmd.seg_on = i_seg_on;
        o_cmd.kind   = i_anim_kind;
        o_cmd.delay  = i_delay_ticks;
        case (i_func) inside
            [ssd_pkg::F_DIGIT:ssd_pkg::F_RAW]: begin
                o_cmd.op  = ssd_pkg::OP_DRAW;
                o_cmd.pat = disp_pat | {7'b0, i_show_dp};
                o_cmd.dp  = i_show_dp;
            end
            ssd_pkg::F_SETSEG, ssd_pkg::F_TOGSEG: begin
                if (i_segment > 8'd7) begin
                    o_cmd.op  = ssd_pkg::OP_NOP;
                    o_cmd.acc = 1'b0;
                end else begin
                    o_cmd.op = (i_func == ssd_pkg::F_SETSEG) ? ssd_pkg::OP_SETSEG
                                                             : ssd_pkg::OP_TOGSEG;
                end
            end
            [ssd_pkg::F_BLANK:ssd_pkg::F_ERROR]: begin
                o_cmd.op  = ssd_pkg::OP_DRAW;
                o_cmd.pat = sym_pat;
                o_cmd.dp  = (i_func == ssd_pkg::F_ALL);
            end
            ssd_pkg::F_START: o_cmd.op = ssd_pkg::OP_START;
            ssd_pkg::F_STOP:  o_cmd.op = ssd_pkg::OP_STOP;
            ssd_pkg::F_TICK:  o_cmd.op = ssd_pkg::OP_TICK;
            default:          o_cmd.op = ssd_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== hdl/ssd_fifo.sv =====
// Two-entry command queue between front and back end.
module ssd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssd_pkg::t_cmd i_data,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output ssd_pkg::t_cmd o_data
);

    ssd_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/ssd_back.sv =====
// Back end: display and animation state, applies one operation per cycle unless the output stalls.
module ssd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_cmd_valid,
    input  ssd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_port_bits,
    output logic          o_dp_lit,
    output logic          o_animating,
    output logic          o_accepted,
    output logic          o_wrote
);

    logic                        r_invert;
    logic [7:0]                  r_port;
    logic                        r_dp;
    logic                        r_run;
    logic [2:0]                  r_mode;
    logic [3:0]                  r_step;
    logic [ssd_pkg::DELAY_W-1:0] r_delay;
    logic [ssd_pkg::DELAY_W-1:0] r_ticks;
    logic                        r_valid;
    logic                        r_acc;
    logic                        r_wrote;

    logic [7:0]                  n_port;
    logic                        n_dp;
    logic                        n_run;
    logic [2:0]                  n_mode;
    logic [3:0]                  n_step;
    logic [ssd_pkg::DELAY_W-1:0] n_delay;
    logic [ssd_pkg::DELAY_W-1:0] n_ticks;
    logic                        n_wrote;

    logic                        take;
    logic [7:0]                  seg_mask;
    logic [ssd_pkg::DELAY_W-1:0] ticks_inc;
    logic [8:0]                  anim_out;
    logic [3:0]                  step_inc;

    // output register frees up when empty or being taken
    assign take      = i_cmd_valid && (!r_valid || i_ready);
    assign o_cmd_pop = take;

    assign seg_mask  = 8'b1 << i_cmd.seg;
    assign ticks_inc = (r_ticks != ssd_pkg::DLY_MASK) ? r_ticks + 1'b1 : r_ticks;
    assign anim_out  = ssd_pkg::anim_pattern(r_mode, r_step);
    assign step_inc  = r_step + 4'd1;

    always_comb begin
        n_port  = r_port;
        n_dp    = r_dp;
        n_run   = r_run;
        n_mode  = r_mode;
        n_step  = r_step;
        n_delay = r_delay;
        n_ticks = r_ticks;
        n_wrote = 1'b0;
        case (i_cmd.op)
            ssd_pkg::OP_DRAW: begin
                n_run   = 1'b0;
                n_dp    = i_cmd.dp;
                n_port  = r_invert ? ~i_cmd.pat : i_cmd.pat;
                n_wrote = 1'b1;
            end
            ssd_pkg::OP_SETSEG: begin
                n_run = 1'b0;
                if (i_cmd.seg == ssd_pkg::BIT_DP) n_dp = i_cmd.seg_on;
                if (r_invert ^ i_cmd.seg_on) n_port = r_port | seg_mask;
                else n_port = r_port & ~seg_mask;
                n_wrote = 1'b1;
            end
            ssd_pkg::OP_TOGSEG: begin
                n_run = 1'b0;
                if (i_cmd.seg == ssd_pkg::BIT_DP) n_dp = ~r_dp;
                n_port  = r_port ^ seg_mask;
                n_wrote = 1'b1;
            end
            ssd_pkg::OP_START: begin
                n_mode  = i_cmd.kind;
                n_delay = i_cmd.delay;
                n_step  = 4'd0;
                n_run   = 1'b1;
                n_ticks = '0;
            end
            ssd_pkg::OP_STOP: begin
                n_run = 1'b0;
            end
            ssd_pkg::OP_TICK: begin
                if (r_run) begin
                    n_ticks = ticks_inc;
                    if (ticks_inc >= r_delay) begin
                        n_ticks = '0;
                        if (anim_out[8]) begin
                            n_port  = r_invert ? ~anim_out[7:0] : anim_out[7:0];
                            n_step  = (step_inc >= ssd_pkg::STEP_WRAP) ? 4'd0 : step_inc;
                            n_wrote = 1'b1;
                            if (r_mode == ssd_pkg::MODE_BLINK) n_dp = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b1;
            r_port   <= 8'h00;
            r_dp     <= 1'b0;
            r_run    <= 1'b0;
            r_mode   <= ssd_pkg::MODE_CW;
            r_step   <= 4'd0;
            r_delay  <= ssd_pkg::DELAY_RST;
            r_ticks  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_invert <= i_cfg_wdata;
            if (take) begin
                r_port  <= n_port;
                r_dp    <= n_dp;
                r_run   <= n_run;
                r_mode  <= n_mode;
                r_step  <= n_step;
                r_delay <= n_delay;
                r_ticks <= n_ticks;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_acc   <= i_cmd.acc;
            r_wrote <= n_wrote;
        end
    end

    assign o_valid     = r_valid;
    assign o_port_bits = r_port;
    assign o_dp_lit    = r_dp;
    assign o_animating = r_run;
    assign o_accepted  = r_acc;
    assign o_wrote     = r_wrote;

endmodule
